>>> hw/rtl/prrs_pkg.sv
// Shared types, constants and codes of the priority round-robin scheduler.
package prrs_pkg;
   localparam int MaxThreads = 16;
   localparam int PriorityLevels = 5;
   localparam int SlotW = $clog2(MaxThreads);
   localparam int PtrW = SlotW + 1;
   localparam int PriW = 3;
   localparam int LevW = (PriorityLevels > 1) ? $clog2(PriorityLevels) : 1;
   localparam int CntW = $clog2(MaxThreads + 1);
   localparam logic [PtrW-1:0] NoSlot = PtrW'(MaxThreads);
   localparam int QueueDepth = 2;

   localparam logic [15:0] TicksReset = 16'd1000;
   localparam logic [7:0] GuardReset = 8'd10;

   localparam logic [2:0] ModePreempt = 3'd0;
   localparam logic [2:0] ModeAdd = 3'd1;
   localparam logic [2:0] ModeSleep = 3'd2;
   localparam logic [2:0] ModeTimer = 3'd3;
   localparam logic [2:0] ModeKill = 3'd4;

   localparam logic [1:0] StatusOk = 2'd0;
   localparam logic [1:0] StatusBadPri = 2'd1;
   localparam logic [1:0] StatusFull = 2'd2;

   localparam logic [0:0] CsrTicks = 1'b0;
   localparam logic [0:0] CsrGuard = 1'b1;

   typedef enum logic [1:0] {
      SLOT_FREE = 2'd0,
      SLOT_ACTIVE = 2'd1,
      SLOT_RUNNING = 2'd2,
      SLOT_SLEEPING = 2'd3
   } slot_state_type;

   typedef enum logic [1:0] {
      CMD_NONE = 2'd0,
      CMD_PREEMPT = 2'd1,
      CMD_ADD = 2'd2,
      CMD_OTHER = 2'd3
   } cmd_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_MUL,
      ST_DISPATCH,
      ST_ADD_LINK,
      ST_REMOVE,
      ST_INSERT_CHK,
      ST_INSERT_WALK,
      ST_WAKE_LINK,
      ST_PICK,
      ST_RESULT
   } exec_state_type;

   typedef struct packed {
      logic [2:0] mode;
      logic [2:0] new_priority;
      logic [31:0] sleep_amount;
      logic [63:0] now_time;
   } req_type;

   typedef struct packed {
      logic [3:0] running_slot;
      logic running_is_idle;
      logic switch_request;
      logic [1:0] status;
      logic [31:0] assigned_id;
      logic timer_armed;
      logic [63:0] wake_deadline;
   } rsp_type;

   typedef struct packed {
      logic [2:0] mode;
      logic bad_priority;
      logic [PriW-1:0] priority_level;
      logic [31:0] sleep_amount;
      logic [63:0] now_time;
   } cmd_type;
endpackage

>>> hw/rtl/priority_round_robin_scheduler.sv
// Top level of the priority round-robin scheduler: registers, front end and back end.
// Events pass through the idle, multiply, dispatch and result states; preempt, sleep and kill
// add a priority search, and a sleep walks the deadline-sorted queue one entry per cycle.
// One event is executed at a time by the back-end sequencer; a two-entry queue lets
// the front end accept further events while it works.
// Synchronous reset frees all slots, empties all rings and the sleep queue, and selects idle.
module priority_round_robin_scheduler (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input prrs_pkg::req_type req_data,
   output logic rsp_valid,
   input logic rsp_stall,
   output prrs_pkg::rsp_type rsp_data,
   input logic csr_valid,
   output logic csr_ready,
   input logic [0:0] csr_index,
   input logic [15:0] csr_data
);
   import prrs_pkg::*;

   logic [15:0] ticks_ff;
   logic [7:0] guard_ff;
   logic cmd_valid, cmd_take;
   cmd_type cmd_data;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         ticks_ff <= TicksReset;
         guard_ff <= GuardReset;
      end else if (csr_valid) begin
         case (csr_index)
            CsrTicks: ticks_ff <= csr_data;
            CsrGuard: guard_ff <= csr_data[7:0];
            default: ticks_ff <= ticks_ff;
         endcase
      end
   end

   prrs_front u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .cmd_valid(cmd_valid),
      .cmd_take(cmd_take),
      .cmd_data(cmd_data)
   );

   prrs_back u_back (
      .clock(clock),
      .reset(reset),
      .cmd_valid(cmd_valid),
      .cmd_take(cmd_take),
      .cmd_data(cmd_data),
      .ticks_per_unit(ticks_ff),
      .rearm_guard(guard_ff),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );
endmodule

>>> hw/rtl/prrs_ram.sv
// Generic simple dual-port RAM with one write port and a registered read port.
module prrs_ram #(
   parameter int Width = 8,
   parameter int Depth = 16
) (
   input logic clock,
   input logic wr_en,
   input logic [$clog2(Depth)-1:0] wr_addr,
   input logic [Width-1:0] wr_data,
   input logic [$clog2(Depth)-1:0] rd_addr,
   output logic [Width-1:0] rd_data
);
   logic [Width-1:0] mem_ff [Depth];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

>>> hw/rtl/prrs_front.sv
// Front end: accepts events, checks the priority and queues commands.
module prrs_front (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_stall,
   input prrs_pkg::req_type req_data,
   output logic cmd_valid,
   input logic cmd_take,
   output prrs_pkg::cmd_type cmd_data
);
   import prrs_pkg::*;

   cmd_type q_ff [QueueDepth];
   cmd_type q_in [QueueDepth];
   logic [1:0] cnt_ff, cnt_in;
   logic push;
   cmd_type cmd_new;

   assign req_stall = (cnt_ff == 2'(QueueDepth));
   assign push = req_valid && !req_stall;
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd_data = q_ff[0];

   always_comb begin
      cmd_new.mode = req_data.mode;
      cmd_new.bad_priority = (32'(req_data.new_priority) >= PriorityLevels);
      cmd_new.priority_level = req_data.new_priority;
      cmd_new.sleep_amount = req_data.sleep_amount;
      cmd_new.now_time = req_data.now_time;
   end

   always_comb begin
      q_in = q_ff;
      cnt_in = cnt_ff;
      if (cmd_take && cmd_valid) begin
         q_in[0] = q_ff[1];
         cnt_in = cnt_ff - 2'd1;
      end
      if (push) begin
         q_in[cnt_in[0]] = cmd_new;
         cnt_in = cnt_in + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= 2'd0;
      end else begin
         cnt_ff <= cnt_in;
      end
      q_ff <= q_in;
   end
endmodule

>>> hw/rtl/prrs_back.sv
// Back end: sequencer that updates the rings and the sleep queue.
module prrs_back (
   input logic clock,
   input logic reset,
   input logic cmd_valid,
   output logic cmd_take,
   input prrs_pkg::cmd_type cmd_data,
   input logic [15:0] ticks_per_unit,
   input logic [7:0] rearm_guard,
   output logic rsp_valid,
   input logic rsp_stall,
   output prrs_pkg::rsp_type rsp_data
);
   import prrs_pkg::*;

   exec_state_type state_ff, state_in;
   cmd_type cmd_ff, cmd_in;
   slot_state_type status_ff [MaxThreads];
   slot_state_type status_in [MaxThreads];
   logic [PriW-1:0] pri_ff [MaxThreads];
   logic [PriW-1:0] pri_in [MaxThreads];
   logic [SlotW-1:0] next_ff [MaxThreads];
   logic [SlotW-1:0] next_in [MaxThreads];
   logic [SlotW-1:0] prev_ff [MaxThreads];
   logic [SlotW-1:0] prev_in [MaxThreads];
   logic [PtrW-1:0] head_ff [PriorityLevels];
   logic [PtrW-1:0] head_in [PriorityLevels];
   logic [CntW-1:0] rcnt_ff [PriorityLevels];
   logic [CntW-1:0] rcnt_in [PriorityLevels];
   logic [PtrW-1:0] shead_ff, shead_in;
   logic [SlotW-1:0] snext_ff [MaxThreads];
   logic [SlotW-1:0] snext_in [MaxThreads];
   logic snone_ff [MaxThreads];
   logic snone_in [MaxThreads];
   logic [PtrW-1:0] cur_ff, cur_in;
   logic [31:0] life_ff, life_in;
   logic [63:0] dl_ff, dl_in;
   logic [63:0] wake_ff, wake_in;
   logic [SlotW-1:0] walk_ff, walk_in;
   logic [SlotW-1:0] tgt_ff, tgt_in;
   logic [LevW-1:0] lev_ff, lev_in;
   logic sw_ff, sw_in;
   logic [1:0] stat_ff, stat_in;
   logic [31:0] asg_ff, asg_in;
   rsp_type rsp_ff, rsp_in;
   logic rv_ff, rv_in;

   logic wt_we;
   logic [SlotW-1:0] wt_waddr, wt_raddr;
   logic [63:0] wt_wdata, wt_rdata;

   prrs_ram #(.Width(64), .Depth(MaxThreads)) u_wake_ram (
      .clock(clock),
      .wr_en(wt_we),
      .wr_addr(wt_waddr),
      .wr_data(wt_wdata),
      .rd_addr(wt_raddr),
      .rd_data(wt_rdata)
   );

   assign rsp_valid = rv_ff;
   assign rsp_data = rsp_ff;

   logic [PtrW-1:0] free_slot;
   always_comb begin
      free_slot = NoSlot;
      for (int i = MaxThreads - 1; i >= 0; i--) begin
         if (status_ff[i] == SLOT_FREE) begin
            free_slot = PtrW'(i);
         end
      end
   end

   logic [SlotW-1:0] cs;
   logic [63:0] lim;
   assign cs = cur_ff[SlotW-1:0];
   assign lim = cmd_ff.now_time + 64'(rearm_guard);

   always_comb begin
      logic [SlotW-1:0] h, t, n, v, s;
      logic [LevW-1:0] p;
      state_in = state_ff;
      cmd_in = cmd_ff;
      status_in = status_ff;
      pri_in = pri_ff;
      next_in = next_ff;
      prev_in = prev_ff;
      head_in = head_ff;
      rcnt_in = rcnt_ff;
      shead_in = shead_ff;
      snext_in = snext_ff;
      snone_in = snone_ff;
      cur_in = cur_ff;
      life_in = life_ff;
      dl_in = dl_ff;
      wake_in = wake_ff;
      walk_in = walk_ff;
      tgt_in = tgt_ff;
      lev_in = lev_ff;
      sw_in = sw_ff;
      stat_in = stat_ff;
      asg_in = asg_ff;
      rsp_in = rsp_ff;
      rv_in = rv_ff;
      cmd_take = 1'b0;
      wt_we = 1'b0;
      wt_waddr = cs;
      wt_wdata = wake_ff;
      wt_raddr = walk_ff;
      h = '0;
      t = '0;
      n = '0;
      v = '0;
      s = '0;
      p = '0;
      if (rv_ff && !rsp_stall) begin
         rv_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_take = 1'b1;
               cmd_in = cmd_data;
               sw_in = 1'b0;
               stat_in = StatusOk;
               asg_in = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            wake_in = 64'(cmd_ff.sleep_amount * 48'(ticks_per_unit));
            state_in = ST_DISPATCH;
         end
         ST_DISPATCH: begin
            wake_in = cmd_ff.now_time + wake_ff;
            state_in = ST_RESULT;
            case (cmd_ff.mode)
               ModePreempt: begin
                  if (cur_ff != NoSlot && status_ff[cs] == SLOT_RUNNING) begin
                     status_in[cs] = SLOT_ACTIVE;
                     rcnt_in[LevW'(pri_ff[cs])] = rcnt_ff[LevW'(pri_ff[cs])] + 1'b1;
                  end
                  sw_in = 1'b1;
                  lev_in = '0;
                  state_in = ST_PICK;
               end
               ModeAdd: begin
                  if (cmd_ff.bad_priority) begin
                     stat_in = StatusBadPri;
                  end else if (free_slot == NoSlot) begin
                     stat_in = StatusFull;
                  end else begin
                     life_in = life_ff + 32'd1;
                     asg_in = life_ff + 32'd1;
                     tgt_in = free_slot[SlotW-1:0];
                     state_in = ST_ADD_LINK;
                  end
               end
               ModeSleep: begin
                  if (cur_ff != NoSlot && cmd_ff.sleep_amount != 32'd0) begin
                     state_in = ST_REMOVE;
                  end
               end
               ModeTimer: begin
                  if (shead_ff != NoSlot) begin
                     tgt_in = shead_ff[SlotW-1:0];
                     walk_in = snext_ff[shead_ff[SlotW-1:0]];
                     wt_raddr = snext_ff[shead_ff[SlotW-1:0]];
                     state_in = ST_WAKE_LINK;
                  end
               end
               ModeKill: begin
                  if (cur_ff != NoSlot) begin
                     state_in = ST_REMOVE;
                  end
               end
               default: begin
                  state_in = ST_RESULT;
               end
            endcase
         end
         ST_ADD_LINK: begin
            s = tgt_ff;
            p = LevW'(cmd_ff.priority_level);
            pri_in[s] = cmd_ff.priority_level;
            status_in[s] = SLOT_ACTIVE;
            if (head_ff[p] == NoSlot) begin
               next_in[s] = s;
               prev_in[s] = s;
               head_in[p] = {1'b0, s};
            end else begin
               h = head_ff[p][SlotW-1:0];
               t = prev_ff[h];
               prev_in[s] = t;
               next_in[t] = s;
               next_in[s] = h;
               prev_in[h] = s;
               if (rcnt_ff[p] == CntW'(1)) begin
                  head_in[p] = {1'b0, s};
               end
            end
            rcnt_in[p] = rcnt_ff[p] + 1'b1;
            state_in = ST_RESULT;
         end
         ST_REMOVE: begin
            p = LevW'(pri_ff[cs]);
            if (next_ff[cs] == cs) begin
               head_in[p] = NoSlot;
            end else begin
               n = next_ff[cs];
               v = prev_ff[cs];
               next_in[v] = n;
               prev_in[n] = v;
               if (head_ff[p] == cur_ff) begin
                  head_in[p] = {1'b0, n};
               end
            end
            sw_in = 1'b1;
            lev_in = '0;
            if (cmd_ff.mode == ModeKill) begin
               status_in[cs] = SLOT_FREE;
               cur_in = NoSlot;
               state_in = ST_PICK;
            end else begin
               status_in[cs] = SLOT_SLEEPING;
               tgt_in = cs;
               wt_we = 1'b1;
               wt_waddr = cs;
               wt_wdata = wake_ff;
               walk_in = shead_ff[SlotW-1:0];
               wt_raddr = shead_ff[SlotW-1:0];
               state_in = ST_INSERT_CHK;
            end
         end
         ST_INSERT_CHK: begin
            if (shead_ff == NoSlot || wake_ff < wt_rdata) begin
               snone_in[tgt_ff] = (shead_ff == NoSlot);
               snext_in[tgt_ff] = shead_ff[SlotW-1:0];
               shead_in = {1'b0, tgt_ff};
               dl_in = wake_ff;
               cur_in = NoSlot;
               state_in = ST_PICK;
            end else begin
               wt_raddr = snext_ff[walk_ff];
               state_in = ST_INSERT_WALK;
            end
         end
         ST_INSERT_WALK: begin
            if (snone_ff[walk_ff] || wake_ff < wt_rdata) begin
               snone_in[tgt_ff] = snone_ff[walk_ff];
               snext_in[tgt_ff] = snext_ff[walk_ff];
               snone_in[walk_ff] = 1'b0;
               snext_in[walk_ff] = tgt_ff;
               cur_in = NoSlot;
               state_in = ST_PICK;
            end else begin
               walk_in = snext_ff[walk_ff];
               wt_raddr = snext_ff[snext_ff[walk_ff]];
            end
         end
         ST_WAKE_LINK: begin
            s = tgt_ff;
            p = LevW'(pri_ff[s]);
            if (snone_ff[s]) begin
               shead_in = NoSlot;
            end else begin
               shead_in = {1'b0, snext_ff[s]};
               dl_in = (wt_rdata < lim) ? lim : wt_rdata;
            end
            if (head_ff[p] == NoSlot) begin
               next_in[s] = s;
               prev_in[s] = s;
            end else begin
               h = head_ff[p][SlotW-1:0];
               t = prev_ff[h];
               next_in[t] = s;
               prev_in[s] = t;
               next_in[s] = h;
               prev_in[h] = s;
            end
            head_in[p] = {1'b0, s};
            rcnt_in[p] = rcnt_ff[p] + 1'b1;
            status_in[s] = SLOT_ACTIVE;
            state_in = ST_RESULT;
         end
         ST_PICK: begin
            if (rcnt_ff[lev_ff] != '0 && head_ff[lev_ff] != NoSlot) begin
               h = head_ff[lev_ff][SlotW-1:0];
               head_in[lev_ff] = {1'b0, next_ff[h]};
               status_in[h] = SLOT_RUNNING;
               rcnt_in[lev_ff] = rcnt_ff[lev_ff] - 1'b1;
               cur_in = {1'b0, h};
               state_in = ST_RESULT;
            end else if (32'(lev_ff) == PriorityLevels - 1) begin
               cur_in = NoSlot;
               state_in = ST_RESULT;
            end else begin
               lev_in = lev_ff + 1'b1;
            end
         end
         ST_RESULT: begin
            if (!rv_ff || !rsp_stall) begin
               rsp_in.running_is_idle = (cur_ff == NoSlot);
               rsp_in.running_slot = (cur_ff == NoSlot) ? 4'd0 : 4'(cur_ff[SlotW-1:0]);
               rsp_in.switch_request = sw_ff;
               rsp_in.status = stat_ff;
               rsp_in.assigned_id = asg_ff;
               rsp_in.timer_armed = (shead_ff != NoSlot);
               rsp_in.wake_deadline = (shead_ff != NoSlot) ? dl_ff : 64'd0;
               rv_in = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         for (int i = 0; i < MaxThreads; i++) begin
            status_ff[i] <= SLOT_FREE;
         end
         for (int i = 0; i < PriorityLevels; i++) begin
            head_ff[i] <= NoSlot;
            rcnt_ff[i] <= '0;
         end
         shead_ff <= NoSlot;
         cur_ff <= NoSlot;
         life_ff <= '0;
         dl_ff <= '0;
         rv_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         status_ff <= status_in;
         head_ff <= head_in;
         rcnt_ff <= rcnt_in;
         shead_ff <= shead_in;
         cur_ff <= cur_in;
         life_ff <= life_in;
         dl_ff <= dl_in;
         rv_ff <= rv_in;
      end
      cmd_ff <= cmd_in;
      pri_ff <= pri_in;
      next_ff <= next_in;
      prev_ff <= prev_in;
      snext_ff <= snext_in;
      snone_ff <= snone_in;
      wake_ff <= wake_in;
      walk_ff <= walk_in;
      tgt_ff <= tgt_in;
      lev_ff <= lev_in;
      sw_ff <= sw_in;
      stat_ff <= stat_in;
      asg_ff <= asg_in;
      rsp_ff <= rsp_in;
   end
endmodule

>>> test/tb.sv
// Self-checking testbench for the priority round-robin scheduler with a built-in predictor.
module tb;
   timeunit 1ns;
   timeprecision 1ps;
   import prrs_pkg::*;

   localparam int IdleLimit = 4000;
   localparam int RandomEvents = 800;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [0:0] csr_index = CsrTicks;
   logic [15:0] csr_data = '0;

   priority_round_robin_scheduler uut (.*);

   always #5 clock = ~clock;

   // Scheduler state as predicted.
   logic [15:0] ticks_q;
   logic [7:0] guard_q;
   logic [2:0] pri_q [MaxThreads];
   slot_state_type state_q [MaxThreads];
   int next_q [MaxThreads];
   int prev_q [MaxThreads];
   logic [63:0] wake_q [MaxThreads];
   int head_q [PriorityLevels];
   int ready_q [PriorityLevels];
   int sleep_head_q;
   int running_q;
   logic [31:0] lifetime_q;
   logic [63:0] deadline_q;

   req_type pending_events [$];
   rsp_type expected_rsps [$];
   int errors = 0;
   int mismatches = 0;
   int idle_cycles = 0;
   bit req_accepted = 1'b0;
   int burst_left = 0;
   int gap_left = 0;

   function automatic void clear_model();
      ticks_q = TicksReset;
      guard_q = GuardReset;
      for (int i = 0; i < MaxThreads; i++) begin
         pri_q[i] = '0;
         state_q[i] = SLOT_FREE;
         next_q[i] = 0;
         prev_q[i] = 0;
         wake_q[i] = '0;
      end
      for (int p = 0; p < PriorityLevels; p++) begin
         head_q[p] = MaxThreads;
         ready_q[p] = 0;
      end
      sleep_head_q = MaxThreads;
      running_q = MaxThreads;
      lifetime_q = '0;
      deadline_q = '0;
   endfunction

   function automatic void unlink_slot(int s);
      int p;
      p = pri_q[s];
      if (next_q[s] == s) begin
         head_q[p] = MaxThreads;
      end else begin
         next_q[prev_q[s]] = next_q[s];
         prev_q[next_q[s]] = prev_q[s];
         if (head_q[p] == s) begin
            head_q[p] = next_q[s];
         end
      end
   endfunction

   function automatic void choose_thread();
      int s;
      for (int p = 0; p < PriorityLevels; p++) begin
         if (ready_q[p] != 0 && head_q[p] < MaxThreads) begin
            s = head_q[p];
            head_q[p] = next_q[s];
            state_q[s] = SLOT_RUNNING;
            ready_q[p]--;
            running_q = s;
            return;
         end
      end
      running_q = MaxThreads;
   endfunction

   function automatic void queue_sleeper(int s, logic [63:0] wake);
      int n;
      int m;
      wake_q[s] = wake;
      if (sleep_head_q >= MaxThreads || wake < wake_q[sleep_head_q]) begin
         next_q[s] = sleep_head_q;
         sleep_head_q = s;
         deadline_q = wake;
         return;
      end
      n = sleep_head_q;
      for (int i = 0; i < MaxThreads; i++) begin
         m = next_q[n];
         if (m >= MaxThreads || wake < wake_q[m]) begin
            next_q[s] = m;
            next_q[n] = s;
            return;
         end
         n = m;
      end
   endfunction

   function automatic void wake_sleeper(logic [63:0] now);
      int s;
      int p;
      int h;
      logic [63:0] lim;
      s = sleep_head_q;
      p = pri_q[s];
      sleep_head_q = next_q[s];
      if (sleep_head_q < MaxThreads) begin
         lim = now + 64'(guard_q);
         deadline_q = (wake_q[sleep_head_q] < lim) ? lim : wake_q[sleep_head_q];
      end
      if (head_q[p] >= MaxThreads) begin
         next_q[s] = s;
         prev_q[s] = s;
      end else begin
         h = head_q[p];
         next_q[prev_q[h]] = s;
         prev_q[s] = prev_q[h];
         next_q[s] = h;
         prev_q[h] = s;
      end
      head_q[p] = s;
      ready_q[p]++;
      state_q[s] = SLOT_ACTIVE;
   endfunction

   function automatic rsp_type schedule_event(req_type ev);
      rsp_type r;
      int s;
      int h;
      int p;
      r = '0;
      case (ev.mode)
         ModePreempt: begin
            if (running_q < MaxThreads && state_q[running_q] == SLOT_RUNNING) begin
               state_q[running_q] = SLOT_ACTIVE;
               ready_q[pri_q[running_q]]++;
            end
            choose_thread();
            r.switch_request = 1'b1;
         end
         ModeAdd: begin
            if (ev.new_priority >= PriorityLevels) begin
               r.status = StatusBadPri;
            end else begin
               s = MaxThreads;
               for (int i = MaxThreads - 1; i >= 0; i--) begin
                  if (state_q[i] == SLOT_FREE) s = i;
               end
               if (s >= MaxThreads) begin
                  r.status = StatusFull;
               end else begin
                  p = ev.new_priority;
                  lifetime_q++;
                  r.assigned_id = lifetime_q;
                  pri_q[s] = ev.new_priority;
                  state_q[s] = SLOT_ACTIVE;
                  if (head_q[p] >= MaxThreads) begin
                     next_q[s] = s;
                     prev_q[s] = s;
                     head_q[p] = s;
                  end else begin
                     h = head_q[p];
                     prev_q[s] = prev_q[h];
                     next_q[prev_q[h]] = s;
                     next_q[s] = h;
                     prev_q[h] = s;
                     if (ready_q[p] == 1) head_q[p] = s;
                  end
                  ready_q[p]++;
               end
            end
         end
         ModeSleep: begin
            if (running_q < MaxThreads && ev.sleep_amount != 0) begin
               s = running_q;
               unlink_slot(s);
               state_q[s] = SLOT_SLEEPING;
               queue_sleeper(s, ev.now_time + 64'(ev.sleep_amount) * 64'(ticks_q));
               running_q = MaxThreads;
               choose_thread();
               r.switch_request = 1'b1;
            end
         end
         ModeTimer: begin
            if (sleep_head_q < MaxThreads) wake_sleeper(ev.now_time);
         end
         ModeKill: begin
            if (running_q < MaxThreads) begin
               unlink_slot(running_q);
               state_q[running_q] = SLOT_FREE;
               running_q = MaxThreads;
               choose_thread();
               r.switch_request = 1'b1;
            end
         end
         default: begin
         end
      endcase
      r.running_is_idle = running_q >= MaxThreads;
      r.running_slot = r.running_is_idle ? 4'd0 : 4'(running_q);
      r.timer_armed = sleep_head_q < MaxThreads;
      r.wake_deadline = r.timer_armed ? deadline_q : 64'd0;
      return r;
   endfunction

   function automatic req_type make_event(logic [2:0] mode, logic [2:0] pri,
                                          logic [31:0] amount, logic [63:0] now);
      req_type ev;
      ev.mode = mode;
      ev.new_priority = pri;
      ev.sleep_amount = amount;
      ev.now_time = now;
      return ev;
   endfunction

   function automatic logic [63:0] rand64();
      return {$urandom(), $urandom()};
   endfunction

   // Mostly small sleeps around a moving clock, with some extreme values.
   function automatic req_type random_event(logic [63:0] now);
      int pick;
      logic [2:0] mode;
      logic [31:0] amount;
      pick = $urandom_range(0, 99);
      if (pick < 25) mode = ModeAdd;
      else if (pick < 50) mode = ModePreempt;
      else if (pick < 68) mode = ModeSleep;
      else if (pick < 85) mode = ModeTimer;
      else if (pick < 95) mode = ModeKill;
      else mode = 3'($urandom_range(0, 7));
      amount = ($urandom_range(0, 9) == 0) ? $urandom() : 32'($urandom_range(0, 20));
      return make_event(mode, ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                        : 3'($urandom_range(0, 4)), amount,
                        ($urandom_range(0, 19) == 0) ? rand64() : now);
   endfunction

   // Driver: bursts with random gaps; a stalled transaction is held.
   always @(negedge clock) begin
      if (!reset && (!req_valid || req_accepted)) begin
         if (req_valid) pending_events.pop_front();
         if (pending_events.size() != 0 && burst_left > 0) begin
            req_valid <= 1'b1;
            req_data <= pending_events[0];
            burst_left--;
         end else begin
            req_valid <= 1'b0;
            if (gap_left > 0) begin
               gap_left--;
            end else begin
               burst_left = $urandom_range(1, 12);
               gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
            end
         end
      end
      if (!reset) rsp_stall <= ($urandom_range(0, 7) < 3) && ($urandom_range(0, 1) == 1);
   end

   // Monitor: predicts on each accepted request, checks each accepted response.
   always @(posedge clock) begin
      if (!reset) begin
         req_accepted = req_valid && !req_stall;
         if (req_valid && !req_stall) expected_rsps.push_back(schedule_event(req_data));
         if (rsp_valid && !rsp_stall) begin
            if (expected_rsps.size() == 0) begin
               errors++;
               $display("Unexpected response transaction: %p", rsp_data);
            end else if (rsp_data !== expected_rsps[0]) begin
               errors++;
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected %p, actual %p", expected_rsps[0], rsp_data);
               void'(expected_rsps.pop_front());
            end else begin
               void'(expected_rsps.pop_front());
            end
         end
         if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
            idle_cycles = 0;
         else if (pending_events.size() != 0 || expected_rsps.size() != 0)
            idle_cycles++;
         if (idle_cycles >= IdleLimit) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   task automatic write_csr(logic [0:0] idx, logic [15:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      @(negedge clock);
      csr_valid <= 1'b0;
      if (idx == CsrTicks) ticks_q = value;
      else guard_q = value[7:0];
   endtask

   task automatic drain();
      while (pending_events.size() != 0 || expected_rsps.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
   endtask

   initial begin
      logic [63:0] now;
      clear_model();
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: bad priorities, full table, sleep ordering, wraps and unused modes.
      pending_events.push_back(make_event(ModeSleep, 3'd0, 32'd5, 64'd0));
      pending_events.push_back(make_event(ModeKill, 3'd0, 32'd0, 64'd0));
      pending_events.push_back(make_event(ModeTimer, 3'd0, 32'd0, 64'd0));
      pending_events.push_back(make_event(ModePreempt, 3'd0, 32'd0, 64'd0));
      for (int i = 0; i < 17; i++)
         pending_events.push_back(make_event(ModeAdd, 3'(i % 5), 32'd0, 64'd0));
      pending_events.push_back(make_event(ModeAdd, 3'd7, 32'd0, 64'd0));
      pending_events.push_back(make_event(ModeAdd, 3'd5, 32'd0, 64'd0));
      pending_events.push_back(make_event(3'd7, 3'd7, 32'hFFFF_FFFF, '1));
      pending_events.push_back(make_event(ModePreempt, 3'd0, 32'd0, 64'd0));
      pending_events.push_back(make_event(ModeSleep, 3'd0, 32'd0, 64'd1));
      pending_events.push_back(make_event(ModeSleep, 3'd0, 32'hFFFF_FFFF, '1));
      pending_events.push_back(make_event(ModeSleep, 3'd0, 32'd3, 64'd100));
      pending_events.push_back(make_event(ModeSleep, 3'd0, 32'd3, 64'd100));
      pending_events.push_back(make_event(ModeTimer, 3'd0, 32'd0, '1));
      pending_events.push_back(make_event(ModeKill, 3'd0, 32'd0, 64'd0));
      drain();

      write_csr(CsrTicks, 16'd0);
      write_csr(CsrGuard, 16'd255);
      now = 64'd1000;
      for (int i = 0; i < 200; i++) begin
         now += 64'($urandom_range(0, 30));
         pending_events.push_back(random_event(now));
      end
      drain();
      write_csr(CsrTicks, 16'hFFFF);
      write_csr(CsrGuard, 16'd0);
      now = 64'hFFFF_FFFF_FFFF_F000;
      for (int i = 0; i < 200; i++) begin
         now += 64'($urandom_range(0, 30));
         pending_events.push_back(random_event(now));
      end
      drain();
      write_csr(CsrTicks, 16'd1);
      write_csr(CsrGuard, 16'($urandom_range(0, 255)));
      now = rand64() >> 4;
      for (int i = 0; i < RandomEvents - 400; i++) begin
         now += 64'($urandom_range(0, 30));
         pending_events.push_back(random_event(now));
      end
      drain();

      if (errors == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end
endmodule
